// ----- hdl/rsd_pkg.sv -----
// types, constants and controller table shared by the midi running status decoder
`timescale 1ns / 1ps

package rsd_pkg;

   localparam int LISTED_CC = 40;

   localparam logic [7:0] FIRST_DROPPED_BYTE = 8'hF6;

   localparam logic [3:0] STATUS_NOTE_OFF   = 4'h8;
   localparam logic [3:0] STATUS_NOTE_ON    = 4'h9;
   localparam logic [3:0] STATUS_CONTROL    = 4'hB;
   localparam logic [3:0] STATUS_PITCH_BEND = 4'hE;

   localparam logic [6:0] CC_ALL_SOUND_OFF = 7'd120;
   localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;

   localparam logic [1:0] FULL_COUNT = 2'd3;
   localparam logic [1:0] RUNNING_COUNT = 2'd1;

   localparam logic [6:0] CC_NUMBERS [LISTED_CC] = '{
      7'd1,  7'd2,  7'd4,  7'd7,  7'd10, 7'd11, 7'd12, 7'd13, 7'd16, 7'd17,
      7'd18, 7'd19, 7'd64, 7'd65, 7'd66, 7'd67, 7'd68, 7'd69, 7'd70, 7'd71,
      7'd72, 7'd73, 7'd74, 7'd75, 7'd76, 7'd77, 7'd78, 7'd79, 7'd80, 7'd81,
      7'd82, 7'd83, 7'd84, 7'd91, 7'd92, 7'd93, 7'd94, 7'd95, 7'd33, 7'd39
   };

   typedef enum logic [2:0] {
      EVENT_NOTE_ON    = 3'd0,
      EVENT_NOTE_OFF   = 3'd1,
      EVENT_CONTROL    = 3'd2,
      EVENT_PITCH_BEND = 3'd3,
      EVENT_PANIC      = 3'd4
   } event_kind_type;

   typedef struct packed {
      event_kind_type event_kind;
      logic [6:0]     key_or_controller;
      logic [6:0]     data_value;
      logic [5:0]     cc_slot;
      logic [13:0]    bend_amount;
      logic           led_level;
   } rsd_result_type;

   typedef struct packed {
      logic       full;
      logic [7:0] status;
      logic [7:0] data1;
      logic [7:0] data2;
   } rsd_message_type;

   typedef struct packed {
      logic           handled;
      logic           emit;
      rsd_result_type result;
   } rsd_decode_type;

endpackage

// ----- hdl/rsd_channels.sv -----
// request and response channel interfaces of the midi running status decoder
`timescale 1ns / 1ps

interface rsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface rsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_kind;
   logic [6:0]  key_or_controller;
   logic [6:0]  data_value;
   logic [5:0]  cc_slot;
   logic [13:0] bend_amount;
   logic        led_level;

   modport source (output valid, output event_kind, output key_or_controller,
                   output data_value, output cc_slot, output bend_amount,
                   output led_level, input ready);
   modport sink (input valid, input event_kind, input key_or_controller,
                 input data_value, input cc_slot, input bend_amount,
                 input led_level, output ready);
endinterface

// ----- hdl/rsd_assembler.sv -----
// message buffer and byte count with running status
`timescale 1ns / 1ps

module rsd_assembler
   import rsd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  logic [7:0]      rx_byte,
   input  logic            handled,
   output rsd_message_type message
);

   logic [1:0] count_ff, count_in;
   logic [7:0] bytes_ff [3];
   logic [7:0] bytes_in [3];
   logic [1:0] count_start;
   logic [1:0] count_fill;
   logic       drop;

   always_comb begin
      drop        = (rx_byte >= FIRST_DROPPED_BYTE);
      count_start = rx_byte[7] ? 2'd0 : count_ff;
      bytes_in    = bytes_ff;
      if (count_start != FULL_COUNT) begin
         bytes_in[count_start] = rx_byte;
         count_fill = count_start + 2'd1;
      end else begin
         count_fill = FULL_COUNT;
      end

      message.full   = (count_fill == FULL_COUNT) && !drop;
      message.status = bytes_in[0];
      message.data1  = bytes_in[1];
      message.data2  = bytes_in[2];

      count_in = count_ff;
      if (accept && !drop) begin
         count_in = (message.full && handled) ? RUNNING_COUNT : count_fill;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         bytes_ff <= '{default: 8'h00};
      end else begin
         count_ff <= count_in;
         if (accept && !drop) begin
            bytes_ff <= bytes_in;
         end
      end
   end

endmodule

// ----- hdl/rsd_decoder.sv -----
// decode of a complete three-byte message, with controller table match
`timescale 1ns / 1ps

module rsd_decoder
   import rsd_pkg::*;
#(
   parameter int TABLE_SIZE = 40
) (
   input  rsd_message_type message,
   output rsd_decode_type  decode
);

   logic [6:0] key;
   logic [6:0] val;
   logic       cc_hit;
   logic [5:0] cc_index;

   always_comb begin
      key      = message.data1[6:0];
      val      = message.data2[6:0];
      cc_hit   = 1'b0;
      cc_index = 6'd0;
      // first matching table entry wins
      for (int i = LISTED_CC - 1; i >= 0; i--) begin
         if (i < TABLE_SIZE && CC_NUMBERS[i] == key) begin
            cc_hit   = 1'b1;
            cc_index = 6'(i);
         end
      end

      decode.handled = 1'b0;
      decode.emit    = 1'b0;
      decode.result  = '{event_kind: EVENT_NOTE_OFF, key_or_controller: key,
                         data_value: val, cc_slot: 6'd0, bend_amount: 14'd0,
                         led_level: 1'b0};
      unique case (message.status[7:4])
         STATUS_NOTE_ON: begin
            decode.handled = 1'b1;
            decode.emit    = 1'b1;
            if (val != 7'd0) begin
               decode.result.event_kind = EVENT_NOTE_ON;
               decode.result.led_level  = 1'b1;
            end
         end
         STATUS_NOTE_OFF: begin
            decode.handled = 1'b1;
            decode.emit    = 1'b1;
         end
         STATUS_CONTROL: begin
            decode.handled = 1'b1;
            if (key == CC_ALL_SOUND_OFF || key == CC_ALL_NOTES_OFF) begin
               decode.emit              = 1'b1;
               decode.result.event_kind = EVENT_PANIC;
            end else begin
               decode.emit              = cc_hit;
               decode.result.event_kind = EVENT_CONTROL;
               decode.result.cc_slot    = cc_index;
            end
         end
         STATUS_PITCH_BEND: begin
            decode.handled = 1'b1;
            decode.emit    = 1'b1;
            decode.result.event_kind        = EVENT_PITCH_BEND;
            decode.result.key_or_controller = 7'd0;
            decode.result.data_value        = 7'd0;
            decode.result.bend_amount       = {val, key};
         end
         default: begin
         end
      endcase

      if (!message.full) begin
         decode.handled = 1'b0;
         decode.emit    = 1'b0;
      end
   end

endmodule

// ----- hdl/rsd_out_stage.sv -----
// result register between the decoder and the response channel
`timescale 1ns / 1ps

module rsd_out_stage
   import rsd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  rsd_decode_type decode,
   output logic           slot_free,
   rsd_rsp_if.source      rsp_chan
);

   logic           valid_ff;
   rsd_result_type result_ff;

   assign slot_free = !valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= decode.emit;
      end else if (rsp_chan.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && decode.emit) begin
         result_ff <= decode.result;
      end
   end

   assign rsp_chan.valid             = valid_ff;
   assign rsp_chan.event_kind        = result_ff.event_kind;
   assign rsp_chan.key_or_controller = result_ff.key_or_controller;
   assign rsp_chan.data_value        = result_ff.data_value;
   assign rsp_chan.cc_slot           = result_ff.cc_slot;
   assign rsp_chan.bend_amount       = result_ff.bend_amount;
   assign rsp_chan.led_level         = result_ff.led_level;

endmodule

// ----- hdl/midi_running_status_decoder.sv -----
// top level of the midi running status decoder
`timescale 1ns / 1ps

// midi running status decoder
// req_chan carries one received serial midi byte per request (rx_byte)
// rsp_chan carries at most one decoded event per request: note on, note off,
//   control change with its table slot, pitch bend or panic
// bytes 0xF6 and up are swallowed, a status byte restarts the message buffer,
//   and after a handled message the status byte stays for running status
// throughput: one request per cycle while rsp_chan.ready stays high, set by the single result register
// an event shows on rsp_chan in the cycle after the byte that completes it is taken
// a byte that completes nothing, or an unhandled status, gives no response
// stall: req_chan.ready stays high while the result register is empty or is
//   being taken in the same cycle; a held result blocks only further requests
// reset (synchronous, active high) clears the byte count, the buffer and
//   the result valid flag
// CC_TABLE_SIZE limits how many entries of the controller table may match

module midi_running_status_decoder
   import rsd_pkg::*;
#(
   parameter int CC_TABLE_SIZE = 40
) (
   input  logic      clock,
   input  logic      reset,
   rsd_req_if.sink   req_chan,
   rsd_rsp_if.source rsp_chan
);

   logic            accept;
   logic            slot_free;
   rsd_message_type message;
   rsd_decode_type  decode;

   // take a request whenever the result register can hold its outcome
   assign req_chan.ready = slot_free;
   assign accept         = req_chan.valid && slot_free;

   // buffer update and count, with running status fallback
   rsd_assembler u_assembler (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_chan.rx_byte),
      .handled (decode.handled),
      .message (message)
   );

   // message decode and parallel controller compare
   rsd_decoder #(
      .TABLE_SIZE (CC_TABLE_SIZE)
   ) u_decoder (
      .message (message),
      .decode  (decode)
   );

   // registered response
   rsd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .decode    (decode),
      .slot_free (slot_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ----- dv/rsd_checker.sv -----
// checker that predicts and compares the events of the midi running status decoder
`timescale 1ns / 1ps

module rsd_checker
   import rsd_pkg::*;
#(
   parameter int CC_TABLE_SIZE = 40
) (
   input  logic clock,
   input  logic reset,
   rsd_req_if   req_mon,
   rsd_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count
);

   // predicted decoder state
   logic [1:0] held_count;
   logic [7:0] held_bytes [3];
   logic [6:0] cc_values [CC_TABLE_SIZE];

   rsd_result_type expected_events [$];
   int mismatches = 0;

   assign fail_count = mismatches;

   // advance the predicted state by one byte, returns 1 when an event comes out
   function automatic logic decode_byte(input logic [7:0] rx, output rsd_result_type ev);
      logic [6:0] d1;
      logic [6:0] d2;
      logic       emit;
      logic       handled;
      ev = '0;
      emit = 1'b0;
      if (rx >= FIRST_DROPPED_BYTE) return 1'b0;
      if (rx[7]) held_count = 2'd0;
      if (held_count < FULL_COUNT) begin
         held_bytes[held_count] = rx;
         held_count = held_count + 2'd1;
      end
      if (held_count == FULL_COUNT) begin
         d1 = held_bytes[1][6:0];
         d2 = held_bytes[2][6:0];
         handled = 1'b1;
         case (held_bytes[0][7:4])
            STATUS_NOTE_ON: begin
               emit = 1'b1;
               ev.key_or_controller = d1;
               if (d2 == 7'd0) begin
                  ev.event_kind = EVENT_NOTE_OFF;
               end else begin
                  ev.event_kind = EVENT_NOTE_ON;
                  ev.data_value = d2;
                  ev.led_level = 1'b1;
               end
            end
            STATUS_NOTE_OFF: begin
               emit = 1'b1;
               ev.event_kind = EVENT_NOTE_OFF;
               ev.key_or_controller = d1;
               ev.data_value = d2;
            end
            STATUS_CONTROL: begin
               if (d1 == CC_ALL_SOUND_OFF || d1 == CC_ALL_NOTES_OFF) begin
                  emit = 1'b1;
                  ev.event_kind = EVENT_PANIC;
                  ev.key_or_controller = d1;
                  ev.data_value = d2;
               end else begin
                  for (int i = 0; i < CC_TABLE_SIZE && i < LISTED_CC; i++) begin
                     if (!emit && CC_NUMBERS[i] == d1) begin
                        emit = 1'b1;
                        cc_values[i] = d2;
                        ev.event_kind = EVENT_CONTROL;
                        ev.key_or_controller = d1;
                        ev.data_value = d2;
                        ev.cc_slot = 6'(i);
                     end
                  end
               end
            end
            STATUS_PITCH_BEND: begin
               emit = 1'b1;
               ev.event_kind = EVENT_PITCH_BEND;
               ev.bend_amount = {d2, d1};
            end
            default: handled = 1'b0;
         endcase
         if (handled) held_count = RUNNING_COUNT;
      end
      return emit;
   endfunction

   task automatic report_field(input string field, input int expected, input int actual);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected, actual);
   endtask

   always @(posedge clock) begin
      rsd_result_type ev;
      rsd_result_type want;
      if (reset) begin
         held_count = 2'd0;
         foreach (held_bytes[i]) held_bytes[i] = 8'd0;
         foreach (cc_values[i]) cc_values[i] = 7'd0;
         expected_events.delete();
      end else begin
         // compare before predicting: a response never belongs to the byte of this edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_events.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected event, kind %0d key %0d value %0d",
                        $time, rsp_mon.event_kind, rsp_mon.key_or_controller,
                        rsp_mon.data_value);
            end else begin
               want = expected_events.pop_front();
               if (rsp_mon.event_kind !== want.event_kind)
                  report_field("event_kind", want.event_kind, rsp_mon.event_kind);
               if (rsp_mon.key_or_controller !== want.key_or_controller)
                  report_field("key_or_controller", want.key_or_controller,
                               rsp_mon.key_or_controller);
               if (rsp_mon.data_value !== want.data_value)
                  report_field("data_value", want.data_value, rsp_mon.data_value);
               if (rsp_mon.cc_slot !== want.cc_slot)
                  report_field("cc_slot", want.cc_slot, rsp_mon.cc_slot);
               if (rsp_mon.bend_amount !== want.bend_amount)
                  report_field("bend_amount", want.bend_amount, rsp_mon.bend_amount);
               if (rsp_mon.led_level !== want.led_level)
                  report_field("led_level", want.led_level, rsp_mon.led_level);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (decode_byte(req_mon.rx_byte, ev)) expected_events.push_back(ev);
         end
      end
      pending_count <= expected_events.size();
   end

endmodule

// ----- dv/tb_midi_running_status_decoder.sv -----
// top of the midi running status decoder testbench: stimulus, response pacing and verdict
`timescale 1ns / 1ps

module tb_midi_running_status_decoder;
   import rsd_pkg::*;

   localparam int CC_TABLE_SIZE = 40;

   // status nibbles the block does not handle
   localparam logic [3:0] STATUS_POLY_PRESSURE    = 4'hA;
   localparam logic [3:0] STATUS_PROGRAM          = 4'hC;
   localparam logic [3:0] STATUS_CHANNEL_PRESSURE = 4'hD;
   localparam logic [3:0] STATUS_SYSTEM           = 4'hF;
   localparam logic [7:0] LAST_BYTE               = 8'hFF;

   localparam int RESET_CYCLES   = 8;
   localparam int RANDOM_ITEMS   = 1100;
   localparam int IDLE_PERCENT   = 34;
   // the receiver goes quiet once this many requests are in
   localparam int HOLDOFF_AT     = 200;
   localparam int HOLDOFF_CYCLES = 300;
   // no idling on either side across this range of requests
   localparam int CALM_FROM      = 500;
   localparam int CALM_TO        = 700;
   localparam int DRAIN_CYCLES   = 10;
   localparam int CYCLE_LIMIT    = 200000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   bytes_sent;
   int   cycle_count;

   rsd_req_if req_chan ();
   rsd_rsp_if rsp_chan ();

   midi_running_status_decoder #(
      .CC_TABLE_SIZE(CC_TABLE_SIZE)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   rsd_checker #(
      .CC_TABLE_SIZE(CC_TABLE_SIZE)
   ) i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // single reset pulse at the start of the run
   initial begin
      reset <= 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
   end

   // run limit, sized far above the slowest correct run
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // response side: random stalls, one long hold-off while requests keep coming,
   // and a calm stretch with ready held high
   initial begin : response_pacing
      int   holdoff_left;
      logic holdoff_done;
      holdoff_left = 0;
      holdoff_done = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!holdoff_done && bytes_sent >= HOLDOFF_AT) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_done = 1'b1;
         end
         if (holdoff_left > 0) begin
            rsp_chan.ready <= 1'b0;
            holdoff_left--;
         end else if (bytes_sent >= CALM_FROM && bytes_sent < CALM_TO) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // offer one byte, with a random gap in front, and wait until it is taken
   task automatic send_byte(input logic [7:0] rx);
      while (!(bytes_sent >= CALM_FROM && bytes_sent < CALM_TO)
             && $urandom_range(99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= rx;
      do @(posedge clock); while (!req_chan.ready);
      // swallowed bytes do not count as requests
      if (rx < FIRST_DROPPED_BYTE) bytes_sent++;
   endtask

   // data byte, sometimes with a swallowed byte of 0xF6 and up in front
   task automatic send_data(input logic [6:0] value);
      if ($urandom_range(99) < 5)
         send_byte(8'($urandom_range(FIRST_DROPPED_BYTE, LAST_BYTE)));
      send_byte({1'b0, value});
   endtask

   function automatic logic [6:0] pick_data();
      case ($urandom_range(9))
         0:       return 7'd0;
         1:       return 7'd127;
         default: return 7'($urandom_range(127));
      endcase
   endfunction

   function automatic logic [6:0] pick_controller();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) return CC_NUMBERS[$urandom_range(LISTED_CC - 1)];
      if (roll < 68) return CC_ALL_SOUND_OFF;
      if (roll < 76) return CC_ALL_NOTES_OFF;
      return pick_data();
   endfunction

   // one random message with running status repeats, or a stray byte
   task automatic send_message();
      int         roll;
      int         repeats;
      logic [3:0] status_kind;
      logic [7:0] status_byte;
      roll = $urandom_range(99);
      if (roll < 10) begin
         send_byte(8'($urandom_range(255)));
         return;
      end
      roll = $urandom_range(99);
      if (roll < 25)      status_kind = STATUS_NOTE_ON;
      else if (roll < 40) status_kind = STATUS_NOTE_OFF;
      else if (roll < 70) status_kind = STATUS_CONTROL;
      else if (roll < 85) status_kind = STATUS_PITCH_BEND;
      else if (roll < 89) status_kind = STATUS_POLY_PRESSURE;
      else if (roll < 92) status_kind = STATUS_PROGRAM;
      else if (roll < 95) status_kind = STATUS_CHANNEL_PRESSURE;
      else                status_kind = STATUS_SYSTEM;
      if (status_kind == STATUS_SYSTEM)
         status_byte = 8'($urandom_range(FIRST_DROPPED_BYTE - 8'd1, {STATUS_SYSTEM, 4'h0}));
      else
         status_byte = {status_kind, 4'($urandom_range(15))};
      send_byte(status_byte);
      repeats = 1 + $urandom_range(3);
      for (int i = 0; i < repeats; i++) begin
         if (status_kind == STATUS_CONTROL) send_data(pick_controller());
         else send_data(pick_data());
         // a cut-off message now and then, the next status restarts the buffer
         if ($urandom_range(99) < 8) return;
         send_data(pick_data());
      end
   endtask

   initial begin : stimulus
      bytes_sent = 0;
      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= 8'd0;
      do @(posedge clock); while (reset);

      // data bytes with no status before them: no event
      send_byte(8'h12);
      send_byte(8'h34);
      send_byte(8'h56);
      // note on at full scale, with the lowest swallowed byte in the middle
      send_byte({STATUS_NOTE_ON, 4'h0});
      send_byte(8'h7F);
      send_byte(FIRST_DROPPED_BYTE);
      send_byte(8'h7F);
      // running status note on with zero velocity turns into note off
      send_byte(8'h40);
      send_byte(8'h00);
      send_byte({STATUS_NOTE_OFF, 4'hF});
      send_byte(8'h00);
      send_byte(8'h01);
      // both panic controllers, then the last table slot and an unmatched controller
      send_byte({STATUS_CONTROL, 4'h5});
      send_byte({1'b0, CC_ALL_SOUND_OFF});
      send_byte(8'h05);
      send_byte({1'b0, CC_ALL_NOTES_OFF});
      send_byte(8'h7F);
      send_byte({1'b0, CC_NUMBERS[LISTED_CC - 1]});
      send_byte(8'h55);
      send_byte(8'h03);
      send_byte(8'h11);
      // full scale pitch bend
      send_byte({STATUS_PITCH_BEND, 4'hF});
      send_byte(8'h7F);
      send_byte(8'h7F);
      // unhandled statuses hold the count at full until a new status arrives
      send_byte({STATUS_POLY_PRESSURE, 4'h0});
      send_byte(8'h10);
      send_byte(8'h20);
      send_byte(8'h30);
      send_byte({STATUS_SYSTEM, 4'h2});
      send_byte(8'h10);
      send_byte(8'h20);

      while (bytes_sent < RANDOM_ITEMS + 30) send_message();
      req_chan.valid <= 1'b0;

      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- midi_running_status_decoder.f -----
hdl/rsd_pkg.sv
hdl/rsd_channels.sv
hdl/rsd_assembler.sv
hdl/rsd_decoder.sv
hdl/rsd_out_stage.sv
hdl/midi_running_status_decoder.sv
dv/rsd_checker.sv
dv/tb_midi_running_status_decoder.sv
